[hdl/usbep0_pkg.sv]
// usbep0_pkg: shared types, codes and constants of the endpoint-zero control sequencer
// no dependencies; imported by every module under hdl

package usbep0_pkg;

    // event codes
    localparam logic [1:0] OP_SETUP     = 2'd0;
    localparam logic [1:0] OP_IN_DONE   = 2'd1;
    localparam logic [1:0] OP_OUT_DONE  = 2'd2;
    localparam logic [1:0] OP_BUS_RESET = 2'd3;

    // endpoint handshake codes
    localparam logic [1:0] HS_NAK   = 2'd0;
    localparam logic [1:0] HS_VALID = 2'd1;
    localparam logic [1:0] HS_STALL = 2'd2;

    // control stages
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_STALLED  = 3'd1;
    localparam logic [2:0] ST_IN_DATA  = 3'd2;
    localparam logic [2:0] ST_IN_LAST  = 3'd3;
    localparam logic [2:0] ST_WAIT_IN  = 3'd4;
    localparam logic [2:0] ST_WAIT_OUT = 3'd5;
    localparam logic [2:0] ST_OUT_DATA = 3'd6;
    localparam logic [2:0] ST_OUT_LAST = 3'd7;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_BUFFER  = 2'd1;
    localparam int CFG_DATA_W = 16;

    localparam logic [6:0]  MPS_RESET        = 7'd64;
    localparam int          MAX_PACKET_BYTES = 64;

    // bmRequestType 0 with bRequest 5
    localparam logic [15:0] SET_ADDRESS_KEY = 16'h0500;
    localparam int          DIR_IN_BIT      = 7;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  req_type;
        logic [7:0]  req_code;
        logic [15:0] req_value;
        logic [15:0] req_length;
        logic [15:0] reply_length;
        logic [9:0]  rx_count;
    } item_t;

    typedef struct packed {
        logic [1:0]  tx_handshake;
        logic [1:0]  rx_handshake;
        logic [6:0]  tx_packet_len;
        logic [15:0] tx_data_offset;
        logic [6:0]  copy_len;
        logic [15:0] copy_offset;
        logic        address_write;
        logic [6:0]  new_address;
        logic        setup_end;
        logic [2:0]  stage;
    } result_t;

    typedef struct packed {
        logic [2:0]  stage;
        logic [15:0] tx_left;
        logic [15:0] tx_sent;
        logic [15:0] rx_left;
        logic [15:0] rx_done;
        logic [31:0] saved_request;   // value 31:16, code 15:8, type 7:0
    } state_t;

    typedef struct packed {
        logic [6:0]  mps;             // packet size in effect
        logic [15:0] rx_buffer_size;
    } cfg_t;

endpackage

[hdl/usbep0_cfg.sv]
// usbep0_cfg: configuration registers and the effective packet size
// depends on usbep0_pkg

module usbep0_cfg #(
    parameter int MAX_PACKET_BYTES = usbep0_pkg::MAX_PACKET_BYTES
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [usbep0_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [usbep0_pkg::CFG_DATA_W-1:0]     cfg_data,
    output usbep0_pkg::cfg_t                      cfg_o
);
    import usbep0_pkg::*;

    localparam logic [9:0] MaxPkt = 10'(MAX_PACKET_BYTES);

    logic [6:0]  mps_reg;
    logic [15:0] rxbuf_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mps_reg   <= MPS_RESET;
            rxbuf_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_PACKET: mps_reg   <= cfg_data[6:0];
                CFG_RX_BUFFER:  rxbuf_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // clamp to the largest packet the endpoint buffers hold
    assign cfg_o.mps = ({3'd0, mps_reg} < MaxPkt) ? mps_reg : MaxPkt[6:0];
    assign cfg_o.rx_buffer_size = rxbuf_reg;

endmodule

[hdl/usbep0_step.sv]
// usbep0_step: next stage, counters and result for one event
// depends on usbep0_pkg

module usbep0_step (
    input  usbep0_pkg::item_t   item_i,
    input  usbep0_pkg::state_t  state_i,
    input  usbep0_pkg::cfg_t    cfg_i,
    output usbep0_pkg::state_t  state_o,
    output usbep0_pkg::result_t result_o
);
    import usbep0_pkg::*;

    logic [15:0] offer_len;
    logic [15:0] src_left;
    logic [15:0] src_sent;
    logic [6:0]  pkt_len;
    logic [15:0] left_after;
    logic [15:0] sent_after;
    logic [2:0]  in_stage;
    logic [15:0] out_expect;
    logic [15:0] cnt_cap;
    logic [6:0]  take_len;
    logic [15:0] rx_left_after;
    logic [15:0] rx_done_after;

    // next IN packet; a setup starts from the freshly offered length
    always_comb begin
        offer_len  = (item_i.req_length < item_i.reply_length) ?
                     item_i.req_length : item_i.reply_length;
        src_left   = (item_i.op == OP_SETUP) ? offer_len : state_i.tx_left;
        src_sent   = (item_i.op == OP_SETUP) ? 16'd0 : state_i.tx_sent;
        pkt_len    = (src_left < {9'd0, cfg_i.mps}) ? src_left[6:0] : cfg_i.mps;
        left_after = src_left - {9'd0, pkt_len};
        sent_after = src_sent + {9'd0, pkt_len};
        // a short packet ends the data; a full one asks for a zero-length follow-up
        in_stage   = (left_after == 16'd0 && pkt_len != cfg_i.mps) ? ST_IN_LAST : ST_IN_DATA;
    end

    // received OUT data, clipped to what is still expected and to the packet size
    always_comb begin
        out_expect    = (item_i.req_length > cfg_i.rx_buffer_size) ?
                        cfg_i.rx_buffer_size : item_i.req_length;
        cnt_cap       = ({6'd0, item_i.rx_count} > state_i.rx_left) ?
                        state_i.rx_left : {6'd0, item_i.rx_count};
        take_len      = (cnt_cap > {9'd0, cfg_i.mps}) ? cfg_i.mps : cnt_cap[6:0];
        rx_left_after = state_i.rx_left - {9'd0, take_len};
        rx_done_after = state_i.rx_done + {9'd0, take_len};
    end

    always_comb begin
        state_o  = state_i;
        result_o = '0;
        result_o.tx_handshake = HS_NAK;
        result_o.rx_handshake = HS_NAK;

        case (item_i.op)
            OP_SETUP: begin
                state_o.saved_request = {item_i.req_value, item_i.req_code, item_i.req_type};
                if (item_i.req_length == 16'd0) begin
                    result_o.tx_handshake = HS_VALID;
                    state_o.stage         = ST_WAIT_IN;
                end else if (item_i.req_type[DIR_IN_BIT]) begin
                    state_o.tx_left          = left_after;
                    state_o.tx_sent          = sent_after;
                    state_o.stage            = in_stage;
                    result_o.tx_packet_len   = pkt_len;
                    result_o.tx_data_offset  = src_sent;
                    result_o.tx_handshake    = HS_VALID;
                    if (in_stage == ST_IN_DATA) begin
                        result_o.rx_handshake = HS_STALL;
                    end
                end else begin
                    state_o.rx_left       = out_expect;
                    state_o.rx_done       = 16'd0;
                    state_o.stage         = (out_expect < {9'd0, cfg_i.mps}) ?
                                            ST_OUT_LAST : ST_OUT_DATA;
                    result_o.rx_handshake = HS_VALID;
                end
            end
            OP_IN_DONE: begin
                if (state_i.stage == ST_WAIT_IN) begin
                    if (state_i.saved_request[15:0] == SET_ADDRESS_KEY) begin
                        result_o.address_write = 1'b1;
                        result_o.new_address   = state_i.saved_request[22:16];
                    end
                    result_o.tx_handshake = HS_STALL;
                    result_o.rx_handshake = HS_STALL;
                    result_o.setup_end    = 1'b1;
                    state_o.stage         = ST_IDLE;
                end else if (state_i.stage == ST_IN_LAST) begin
                    state_o.stage         = ST_WAIT_OUT;
                    result_o.rx_handshake = HS_VALID;
                end else begin
                    state_o.tx_left         = left_after;
                    state_o.tx_sent         = sent_after;
                    state_o.stage           = in_stage;
                    result_o.tx_packet_len  = pkt_len;
                    result_o.tx_data_offset = src_sent;
                    result_o.tx_handshake   = HS_VALID;
                    if (in_stage == ST_IN_DATA) begin
                        result_o.rx_handshake = HS_STALL;
                    end
                end
            end
            OP_OUT_DONE: begin
                if (state_i.stage == ST_WAIT_OUT) begin
                    state_o.stage         = ST_IDLE;
                    result_o.rx_handshake = HS_VALID;
                end else if (state_i.stage == ST_IN_DATA || state_i.stage == ST_IN_LAST) begin
                    // host sent data while we were sending: stall both ways
                    state_o.stage         = ST_STALLED;
                    result_o.tx_handshake = HS_STALL;
                    result_o.rx_handshake = HS_STALL;
                end else begin
                    result_o.copy_len    = take_len;
                    result_o.copy_offset = state_i.rx_done;
                    state_o.rx_done      = rx_done_after;
                    state_o.rx_left      = rx_left_after;
                    if (state_i.stage == ST_OUT_LAST) begin
                        state_o.stage         = ST_WAIT_IN;
                        result_o.tx_handshake = HS_VALID;
                    end else begin
                        if (rx_left_after < {9'd0, cfg_i.mps}) begin
                            state_o.stage = ST_OUT_LAST;
                        end
                        result_o.rx_handshake = HS_VALID;
                    end
                end
            end
            default: begin
                // bus reset
                state_o                = '0;
                state_o.stage          = ST_IDLE;
                result_o.address_write = 1'b1;
                result_o.new_address   = 7'd0;
            end
        endcase

        result_o.stage = state_o.stage;
    end

endmodule

[hdl/usb_control_endpoint_stage_fsm_top.sv]
// usb_control_endpoint_stage_fsm_top: endpoint-zero control sequencer top level
// depends on usbep0_pkg, usbep0_cfg and usbep0_step

// Endpoint-zero control sequencer. Each transfer on the s_ channel is one event (setup
// packet, IN done, OUT done, bus reset) and yields exactly one transfer on the m_ channel
// carrying the handshakes to program, the packet to load, the bytes to copy, any address
// write and the new stage. The event is captured in an input register, evaluated against
// the stage and byte counters, and the result is captured in an output register; m_valid
// rises when the output register takes the result, which waits while an earlier result
// is still held with m_ready low, and one event is accepted every cycle as long as m_ready
// keeps up. The rate is set by the single state update per
// cycle in the step logic. The configuration registers (index 0 packet size, index 1
// receive buffer size) are always ready and are meant to be written only while no event
// is in flight. The packet size in effect is the smaller of the register and the
// MAX_PACKET_BYTES parameter.

module usb_control_endpoint_stage_fsm_top #(
    parameter int MAX_PACKET_BYTES = usbep0_pkg::MAX_PACKET_BYTES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [usbep0_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [usbep0_pkg::CFG_DATA_W-1:0]  cfg_data,
    // events in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_op,
    input  logic [7:0]                         s_req_type,
    input  logic [7:0]                         s_req_code,
    input  logic [15:0]                        s_req_value,
    input  logic [15:0]                        s_req_length,
    input  logic [15:0]                        s_reply_length,
    input  logic [9:0]                         s_rx_count,
    // results out
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_tx_handshake,
    output logic [1:0]                         m_rx_handshake,
    output logic [6:0]                         m_tx_packet_len,
    output logic [15:0]                        m_tx_data_offset,
    output logic [6:0]                         m_copy_len,
    output logic [15:0]                        m_copy_offset,
    output logic                               m_address_write,
    output logic [6:0]                         m_new_address,
    output logic                               m_setup_end,
    output logic [2:0]                         m_stage
);
    import usbep0_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_vld_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    result_vld_reg;
    logic    advance;

    usbep0_cfg #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    // held event moves on when the output register is free or being emptied
    assign advance = item_vld_reg && (!result_vld_reg || m_ready);
    assign s_ready = !item_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
        end else if (s_ready) begin
            item_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.op           <= s_op;
            item_reg.req_type     <= s_req_type;
            item_reg.req_code     <= s_req_code;
            item_reg.req_value    <= s_req_value;
            item_reg.req_length   <= s_req_length;
            item_reg.reply_length <= s_reply_length;
            item_reg.rx_count     <= s_rx_count;
        end
    end

    usbep0_step u_step (
        .item_i   (item_reg),
        .state_i  (state_reg),
        .cfg_i    (cfg),
        .state_o  (state_next),
        .result_o (result_next)
    );

    // stage and counters commit only when the event's result is captured
    // all zero at reset, which is the idle stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_vld_reg <= 1'b0;
        end else if (advance) begin
            result_vld_reg <= 1'b1;
        end else if (m_ready) begin
            result_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = result_vld_reg;
    assign m_tx_handshake   = result_reg.tx_handshake;
    assign m_rx_handshake   = result_reg.rx_handshake;
    assign m_tx_packet_len  = result_reg.tx_packet_len;
    assign m_tx_data_offset = result_reg.tx_data_offset;
    assign m_copy_len       = result_reg.copy_len;
    assign m_copy_offset    = result_reg.copy_offset;
    assign m_address_write  = result_reg.address_write;
    assign m_new_address    = result_reg.new_address;
    assign m_setup_end      = result_reg.setup_end;
    assign m_stage          = result_reg.stage;

endmodule
